// ----- rtl/core/nhlp_pkg.sv -----
package nhlp_pkg;

    localparam int DEF_MAX_TABLE_LOG2 = 10;
    localparam int MIN_TABLE_LOG2     = 4;
    // wide enough for the largest MAX_TABLE_LOG2 (16)
    localparam int LOG_W  = 5;

    localparam int KIND_W = 2;
    localparam int BYTE_W = 8;
    localparam int SLOT_W = 10;
    localparam int HASH_W = 64;
    localparam int IDX_W  = 10;
    localparam int CNT_W  = 11;
    localparam int CFG_W  = 4;

    localparam logic [HASH_W-1:0] FNV_BASIS = 64'hcbf2_9ce4_8422_2325;
    // FNV-64 prime is 2^40 + 0x1b3
    localparam int                FNV_PRIME_SHIFT = 40;
    localparam logic [8:0]        FNV_PRIME_LO    = 9'h1b3;

    typedef enum logic [KIND_W-1:0] {
        KIND_BYTE  = 2'd0,
        KIND_READ  = 2'd1,
        KIND_CLEAR = 2'd2
    } t_kind;

    localparam logic RES_INSERT = 1'b0;
    localparam logic RES_READ   = 1'b1;

    typedef struct packed {
        logic              step;
        logic              last;
        logic [BYTE_W-1:0] name_byte;
    } t_hash_req;

    typedef struct packed {
        logic              result_kind;
        logic [SLOT_W-1:0] slot;
        logic [HASH_W-1:0] bucket_hash;
        logic [IDX_W-1:0]  entry_index;
        logic              occupied;
        logic              table_full;
    } t_result;

endpackage

// ----- rtl/core/nhlp_if.sv -----
interface nhlp_in_if;
    import nhlp_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [BYTE_W-1:0]   name_byte;
    logic                name_last;
    logic [SLOT_W-1:0]   read_slot;

    modport source (output valid, output kind, output name_byte, output name_last,
                    output read_slot, input ready);
    modport sink   (input valid, input kind, input name_byte, input name_last,
                    input read_slot, output ready);
endinterface

interface nhlp_out_if;
    import nhlp_pkg::*;

    logic                valid;
    logic                ready;
    logic                result_kind;
    logic [SLOT_W-1:0]   slot;
    logic [HASH_W-1:0]   bucket_hash;
    logic [IDX_W-1:0]    entry_index;
    logic                occupied;
    logic                table_full;

    modport source (output valid, output result_kind, output slot, output bucket_hash,
                    output entry_index, output occupied, output table_full, input ready);
    modport sink   (input valid, input result_kind, input slot, input bucket_hash,
                    input entry_index, input occupied, input table_full, output ready);
endinterface

// ----- rtl/core/name_hash_linear_probe_table_top.sv -----
// Name byte that is not last: taken in ST_IDLE, ready again the next cycle.
// Last byte: ST_HOME, ST_PROBE and ST_EMIT to the result register; k buckets probed
// one per cycle through the single table read port (k up to the table size in use).
// Bucket read: ST_READ, ST_EMIT. Clear request: sweep of all 2^MAX_TABLE_LOG2 buckets.
// After reset the same sweep runs before the first request is taken;
// configuration writes are taken throughout.
module name_hash_linear_probe_table_top #(
    parameter int MAX_TABLE_LOG2 = nhlp_pkg::DEF_MAX_TABLE_LOG2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [nhlp_pkg::CFG_W-1:0]    i_cfg_data,
    nhlp_in_if.sink                       i_in,
    nhlp_out_if.source                    o_out
);
    import nhlp_pkg::*;

    logic [CFG_W-1:0]  r_size_log2;
    t_hash_req         hash_req;
    logic [HASH_W-1:0] hash_val;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size_log2 <= CFG_W'(MIN_TABLE_LOG2);
        end else if (i_cfg_we) begin
            r_size_log2 <= i_cfg_data;
        end
    end

    nhlp_hash u_hash (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (hash_req),
        .o_hash  (hash_val)
    );

    nhlp_table #(
        .MAX_TABLE_LOG2 (MAX_TABLE_LOG2)
    ) u_table (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_size_log2 (r_size_log2),
        .i_hash      (hash_val),
        .o_hash_req  (hash_req),
        .i_in        (i_in),
        .o_out       (o_out)
    );

endmodule

// ----- rtl/core/nhlp_hash.sv -----
module nhlp_hash (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  nhlp_pkg::t_hash_req           i_req,
    output logic [nhlp_pkg::HASH_W-1:0]   o_hash
);
    import nhlp_pkg::*;

    logic [HASH_W-1:0] r_running;
    logic [HASH_W-1:0] r_final;
    logic [HASH_W-1:0] mixed;
    logic [HASH_W-1:0] prod_lo;
    logic [HASH_W-1:0] n_hash;

    assign mixed   = r_running ^ {{(HASH_W-BYTE_W){1'b0}}, i_req.name_byte};
    // multiply by the prime as a shift plus a narrow product
    assign prod_lo = mixed * FNV_PRIME_LO;
    assign n_hash  = (mixed << FNV_PRIME_SHIFT) + prod_lo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_running <= FNV_BASIS;
        end else if (i_req.step) begin
            r_running <= i_req.last ? FNV_BASIS : n_hash;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.step) begin
            r_final <= n_hash;
        end
    end

    assign o_hash = r_final;

`ifndef ASSERT_OFF
    a_basis_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.step && i_req.last |=> r_running == FNV_BASIS)
        else $error("running hash not restored after last byte");
    a_final_tracks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.step && !i_req.last |=> r_running == r_final)
        else $error("running hash and final hash diverged");
`endif

endmodule

// ----- rtl/core/nhlp_table.sv -----
module nhlp_table #(
    parameter int MAX_TABLE_LOG2 = nhlp_pkg::DEF_MAX_TABLE_LOG2
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [nhlp_pkg::CFG_W-1:0]    i_size_log2,
    input  logic [nhlp_pkg::HASH_W-1:0]   i_hash,
    output nhlp_pkg::t_hash_req           o_hash_req,
    nhlp_in_if.sink                       i_in,
    nhlp_out_if.source                    o_out
);
    import nhlp_pkg::*;

    localparam int AW    = MAX_TABLE_LOG2;
    localparam int DEPTH = 1 << AW;

    typedef struct packed {
        logic              valid;
        logic [IDX_W-1:0]  idx;
        logic [HASH_W-1:0] hash;
    } t_entry;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HOME,
        ST_PROBE,
        ST_READ,
        ST_EMIT
    } t_state;

    t_entry          r_mem [DEPTH];
    t_entry          r_rd_data;
    t_state          r_state;
    logic [AW-1:0]   r_addr;
    logic [AW-1:0]   r_count;
    logic [CNT_W-1:0] r_cnt;
    t_result         r_res;
    t_result         r_out;
    logic            r_out_valid;

    logic            accept;
    logic [LOG_W-1:0] lg;
    logic [AW-1:0]   mask;
    logic [AW-1:0]   next_pos;
    logic [AW-1:0]   home_pos;
    logic [AW+SLOT_W-1:0] slot_ext;
    logic [AW-1:0]   slot_addr;
    logic [AW+SLOT_W-1:0] pos_ext;
    logic [SLOT_W-1:0] pos_slot;
    logic [AW-1:0]   rd_addr;
    logic            wr_en;
    logic [AW-1:0]   wr_addr;
    t_entry          wr_data;

    assign accept = i_in.valid && i_in.ready;
    assign i_in.ready = (r_state == ST_IDLE);

    assign o_hash_req.step      = accept && (i_in.kind == KIND_BYTE);
    assign o_hash_req.last      = i_in.name_last;
    assign o_hash_req.name_byte = i_in.name_byte;

    // clamp the configured size into the supported range
    always_comb begin
        if ({1'b0, i_size_log2} < LOG_W'(MIN_TABLE_LOG2)) begin
            lg = LOG_W'(MIN_TABLE_LOG2);
        end else if ({1'b0, i_size_log2} > LOG_W'(MAX_TABLE_LOG2)) begin
            lg = LOG_W'(MAX_TABLE_LOG2);
        end else begin
            lg = {1'b0, i_size_log2};
        end
    end

    assign mask      = ~({AW{1'b1}} << lg);
    assign home_pos  = i_hash[AW-1:0] & mask;
    assign next_pos  = (r_addr + 1'b1) & mask;
    assign slot_ext  = {{AW{1'b0}}, i_in.read_slot};
    assign slot_addr = slot_ext[AW-1:0];
    assign pos_ext   = {{SLOT_W{1'b0}}, r_addr};
    assign pos_slot  = pos_ext[SLOT_W-1:0];

    always_comb begin
        unique case (r_state)
            ST_IDLE:  rd_addr = slot_addr;
            ST_HOME:  rd_addr = home_pos;
            ST_PROBE: rd_addr = next_pos;
            default:  rd_addr = r_addr;
        endcase
    end

    always_comb begin
        wr_addr = r_addr;
        wr_en   = 1'b0;
        wr_data = '0;
        if (r_state == ST_CLEAR) begin
            wr_en = 1'b1;
        end else if (r_state == ST_PROBE && !r_rd_data.valid) begin
            wr_en   = 1'b1;
            wr_data = '{valid: 1'b1, idx: r_cnt[IDX_W-1:0], hash: i_hash};
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd_data <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_addr      <= '0;
            r_count     <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            // the emit state reloads the output register itself
            if (r_out_valid && o_out.ready && r_state != ST_EMIT) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    r_addr <= r_addr + 1'b1;
                    if (r_addr == {AW{1'b1}}) begin
                        r_state <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (accept) begin
                        unique case (i_in.kind)
                            KIND_BYTE: begin
                                if (i_in.name_last) begin
                                    r_state <= ST_HOME;
                                end
                            end
                            KIND_READ: begin
                                r_addr  <= slot_addr;
                                r_state <= ST_READ;
                            end
                            KIND_CLEAR: begin
                                r_addr  <= '0;
                                r_cnt   <= '0;
                                r_state <= ST_CLEAR;
                            end
                            default: ;
                        endcase
                    end
                end
                ST_HOME: begin
                    r_addr  <= home_pos;
                    r_count <= '0;
                    r_state <= ST_PROBE;
                end
                ST_PROBE: begin
                    if (!r_rd_data.valid) begin
                        r_res <= '{result_kind: RES_INSERT, slot: pos_slot,
                                   bucket_hash: i_hash, entry_index: r_cnt[IDX_W-1:0],
                                   occupied: 1'b1, table_full: 1'b0};
                        r_cnt   <= r_cnt + 1'b1;
                        r_state <= ST_EMIT;
                    end else if (r_count == mask) begin
                        // every bucket in use is taken: drop the insert
                        r_res <= '{result_kind: RES_INSERT, slot: '0,
                                   bucket_hash: i_hash, entry_index: r_cnt[IDX_W-1:0],
                                   occupied: 1'b0, table_full: 1'b1};
                        r_state <= ST_EMIT;
                    end else begin
                        r_addr  <= next_pos;
                        r_count <= r_count + 1'b1;
                    end
                end
                ST_READ: begin
                    if (r_rd_data.valid) begin
                        r_res <= '{result_kind: RES_READ, slot: pos_slot,
                                   bucket_hash: r_rd_data.hash,
                                   entry_index: r_rd_data.idx,
                                   occupied: 1'b1, table_full: 1'b0};
                    end else begin
                        r_res <= '{result_kind: RES_READ, slot: pos_slot,
                                   bucket_hash: '0, entry_index: '0,
                                   occupied: 1'b0, table_full: 1'b0};
                    end
                    r_state <= ST_EMIT;
                end
                ST_EMIT: begin
                    if (!r_out_valid || o_out.ready) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.result_kind = r_out.result_kind;
    assign o_out.slot        = r_out.slot;
    assign o_out.bucket_hash = r_out.bucket_hash;
    assign o_out.entry_index = r_out.entry_index;
    assign o_out.occupied    = r_out.occupied;
    assign o_out.table_full  = r_out.table_full;

`ifndef ASSERT_OFF
    a_insert_counts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PROBE && !r_rd_data.valid |=> r_cnt == CNT_W'($past(r_cnt) + 1'b1))
        else $error("entry counter not advanced on insert");
    a_clear_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && i_in.kind == KIND_CLEAR |=> r_state == ST_CLEAR && r_cnt == '0)
        else $error("clear request did not start the sweep");
    a_result_sane: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_out.occupied && r_out.table_full))
        else $error("result both occupied and full");
    a_probe_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_PROBE |-> (r_count & ~mask) == '0 && (r_addr & ~mask) == '0)
        else $error("probe left the table in use");
`endif

endmodule

// ----- verif/tb_name_hash_linear_probe_table_top.sv -----
import nhlp_pkg::*;

localparam logic [HASH_W-1:0] FNV64_PRIME = 64'h0000_0100_0000_01b3;
localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

class name_table_scoreboard;
    logic [CFG_W-1:0]  size_reg;
    logic [HASH_W-1:0] name_hash;
    bit                bucket_used  [1 << DEF_MAX_TABLE_LOG2];
    logic [HASH_W-1:0] bucket_hash  [1 << DEF_MAX_TABLE_LOG2];
    logic [IDX_W-1:0]  bucket_entry [1 << DEF_MAX_TABLE_LOG2];
    logic [CNT_W-1:0]  next_index;
    logic [SLOT_W-1:0] last_fill_slot;
    t_result           pending_results [$];
    int                mismatch_count;

    function new();
        size_reg       = CFG_W'(MIN_TABLE_LOG2);
        name_hash      = FNV_BASIS;
        next_index     = '0;
        last_fill_slot = '0;
        mismatch_count = 0;
        foreach (bucket_used[i]) begin
            bucket_used[i]  = 1'b0;
            bucket_hash[i]  = '0;
            bucket_entry[i] = '0;
        end
    endfunction

    // buckets in use, register clamped to the supported range
    function int unsigned used_span();
        int unsigned lg;
        lg = size_reg;
        if (lg < MIN_TABLE_LOG2)
            lg = MIN_TABLE_LOG2;
        if (lg > DEF_MAX_TABLE_LOG2)
            lg = DEF_MAX_TABLE_LOG2;
        return 1 << lg;
    endfunction

    function void note_request(logic [KIND_W-1:0] k, logic [BYTE_W-1:0] b, logic is_last,
                               logic [SLOT_W-1:0] s);
        logic [HASH_W-1:0] h;
        int unsigned       span;
        int unsigned       pos;
        int unsigned       n;
        bit                placed;
        t_result           r;
        r = '0;
        if (k == KIND_BYTE) begin
            h = (name_hash ^ {{(HASH_W-BYTE_W){1'b0}}, b}) * FNV64_PRIME;
            if (!is_last) begin
                name_hash = h;
                return;
            end
            name_hash = FNV_BASIS;
            span      = used_span();
            pos       = int'(h[SLOT_W-1:0]) & (span - 1);
            placed    = 1'b0;
            for (n = 0; n < span && !placed; n++) begin
                if (!bucket_used[pos]) begin
                    placed            = 1'b1;
                    bucket_used[pos]  = 1'b1;
                    bucket_hash[pos]  = h;
                    bucket_entry[pos] = next_index[IDX_W-1:0];
                    r.slot            = SLOT_W'(pos);
                    r.entry_index     = next_index[IDX_W-1:0];
                    r.occupied        = 1'b1;
                    next_index        = next_index + 1'b1;
                    last_fill_slot    = r.slot;
                end else begin
                    pos = (pos + 1) & (span - 1);
                end
            end
            r.result_kind = RES_INSERT;
            r.bucket_hash = h;
            // no empty bucket: insert dropped, counter untouched
            if (!placed) begin
                r.entry_index = next_index[IDX_W-1:0];
                r.table_full  = 1'b1;
            end
            pending_results.push_back(r);
        end else if (k == KIND_READ) begin
            r.result_kind = RES_READ;
            r.slot        = s;
            if (bucket_used[s]) begin
                r.bucket_hash = bucket_hash[s];
                r.entry_index = bucket_entry[s];
                r.occupied    = 1'b1;
            end
            pending_results.push_back(r);
        end else if (k == KIND_CLEAR) begin
            foreach (bucket_used[i])
                bucket_used[i] = 1'b0;
            next_index = '0;
        end
    endfunction

    function void check_result(t_result got);
        t_result want;
        if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
                $display("%0t: result with nothing expected: kind=%0d slot=%0d hash=%h",
                         $time, got.result_kind, got.slot, got.bucket_hash);
            return;
        end
        want = pending_results.pop_front();
        if (got.result_kind !== want.result_kind || got.slot !== want.slot ||
            got.bucket_hash !== want.bucket_hash || got.entry_index !== want.entry_index ||
            got.occupied !== want.occupied || got.table_full !== want.table_full) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
                $display("%0t: result mismatch", $time);
                $display("  exp kind=%0d slot=%0d hash=%h idx=%0d occ=%0d full=%0d",
                         want.result_kind, want.slot, want.bucket_hash, want.entry_index,
                         want.occupied, want.table_full);
                $display("  got kind=%0d slot=%0d hash=%h idx=%0d occ=%0d full=%0d",
                         got.result_kind, got.slot, got.bucket_hash, got.entry_index,
                         got.occupied, got.table_full);
            end
        end
    endfunction
endclass

module tb_name_hash_linear_probe_table_top;

    localparam int SWEEP_WAIT  = (1 << DEF_MAX_TABLE_LOG2) + 64;
    localparam int CYCLE_LIMIT = 5_000_000;

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_we;
    logic [CFG_W-1:0] i_cfg_data;

    nhlp_in_if  req_if ();
    nhlp_out_if res_if ();

    name_table_scoreboard sb = new();

    int      burst_left = 0;
    t_result seen;

    name_hash_linear_probe_table_top i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_in       (req_if),
        .o_out      (res_if)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("** name_hash_linear_probe_table_top: FAILED **");
        $finish;
    end

    // receiver: back-pressure mode picked at random, from always ready to rarely ready
    initial begin : result_sink
        int mode;
        int mode_left;
        mode_left    = 0;
        res_if.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (mode_left == 0) begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 300);
            end
            mode_left--;
            case (mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= 1'($urandom);
                2:       res_if.ready <= ($urandom_range(0, 7) == 0);
                default: res_if.ready <= ($urandom_range(0, 9) != 0);
            endcase
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && res_if.valid && res_if.ready) begin
            seen.result_kind = res_if.result_kind;
            seen.slot        = res_if.slot;
            seen.bucket_hash = res_if.bucket_hash;
            seen.entry_index = res_if.entry_index;
            seen.occupied    = res_if.occupied;
            seen.table_full  = res_if.table_full;
            sb.check_result(seen);
        end
    end

    // one request; entered and left at a falling edge
    task automatic send_req(input logic [KIND_W-1:0] k, input logic [BYTE_W-1:0] b,
                            input logic is_last, input logic [SLOT_W-1:0] s);
        int gap;
        if (burst_left == 0) begin
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 3);
            if (gap != 0) begin
                req_if.valid <= 1'b0;
                repeat (gap) @(negedge i_clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 40);
        end
        burst_left--;
        req_if.valid     <= 1'b1;
        req_if.kind      <= k;
        req_if.name_byte <= b;
        req_if.name_last <= is_last;
        req_if.read_slot <= s;
        do @(posedge i_clk); while (!req_if.ready);
        sb.note_request(k, b, is_last, s);
        @(negedge i_clk);
    endtask

    task automatic settle(input int extra);
        req_if.valid <= 1'b0;
        do @(negedge i_clk); while (sb.pending_results.size() != 0);
        repeat (extra) @(negedge i_clk);
    endtask

    // a clear produces no result but keeps the block busy for a full sweep
    task automatic write_table_size(input logic [CFG_W-1:0] v);
        settle(SWEEP_WAIT);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(negedge i_clk);
        i_cfg_we   <= 1'b0;
        sb.size_reg = v;
    endtask

    task automatic stream_names(input int n_items, input int read_pct, input int clear_pm,
                                input int multi_pct, input int max_len);
        int                sent;
        int                len;
        int                pick;
        int                i;
        logic [SLOT_W-1:0] rs;
        sent = 0;
        while (sent < n_items) begin
            pick = $urandom_range(0, 999);
            if (pick < clear_pm) begin
                send_req(KIND_CLEAR, BYTE_W'($urandom), 1'($urandom), SLOT_W'($urandom));
            end else if (pick < clear_pm + 10) begin
                send_req(KIND_UNUSED, BYTE_W'($urandom), 1'($urandom), SLOT_W'($urandom));
            end else if (pick < clear_pm + 10 + read_pct * 10) begin
                case ($urandom_range(0, 2))
                    0:       rs = SLOT_W'($urandom);
                    1:       rs = SLOT_W'($urandom_range(0, sb.used_span() - 1));
                    default: rs = sb.last_fill_slot;
                endcase
                send_req(KIND_READ, BYTE_W'($urandom), 1'($urandom), rs);
            end else begin
                len = ($urandom_range(0, 99) < multi_pct) ? $urandom_range(2, max_len) : 1;
                for (i = 0; i < len; i++) begin
                    // stray request inside a name; the partial hash must survive it
                    if (i != 0 && $urandom_range(0, 19) == 0) begin
                        send_req((clear_pm != 0 && $urandom_range(0, 1)) ? KIND_CLEAR : KIND_READ,
                                 BYTE_W'($urandom), 1'($urandom), SLOT_W'($urandom));
                        sent++;
                    end
                    send_req(KIND_BYTE, BYTE_W'($urandom), (i == len - 1), SLOT_W'($urandom));
                end
                sent += len - 1;
            end
            sent++;
        end
    endtask

    initial begin : stimulus
        int i;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_data       = '0;
        req_if.valid     = 1'b0;
        req_if.kind      = '0;
        req_if.name_byte = '0;
        req_if.name_last = 1'b0;
        req_if.read_slot = '0;
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // empty buckets at both ends of the store, the far one outside the table
        send_req(KIND_READ, 8'h00, 1'b0, '0);
        send_req(KIND_READ, 8'hFF, 1'b1, '1);
        send_req(KIND_UNUSED, 8'hFF, 1'b1, '1);
        // partial name carried across a clear
        send_req(KIND_BYTE, 8'hA5, 1'b0, '0);
        send_req(KIND_CLEAR, 8'h00, 1'b0, '0);
        send_req(KIND_BYTE, 8'h5A, 1'b1, '0);
        send_req(KIND_READ, 8'h00, 1'b0, sb.last_fill_slot);
        // fill all 16 buckets, the last name finds none free
        for (i = 0; i < 16; i++)
            send_req(KIND_BYTE, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : BYTE_W'($urandom),
                     1'b1, SLOT_W'($urandom));
        send_req(KIND_READ, 8'h00, 1'b0, SLOT_W'(15));

        write_table_size(4'd15);
        stream_names(150, 20, 5, 60, 8);
        // shrink without clearing: old entries stay readable past the table
        write_table_size(4'd0);
        stream_names(100, 30, 30, 30, 4);
        write_table_size(4'd10);
        stream_names(330, 5, 0, 15, 3);
        settle(0);
        stream_names(330, 5, 0, 15, 3);
        write_table_size(4'd7);
        stream_names(80, 25, 15, 30, 4);
        write_table_size(4'd5);
        stream_names(50, 25, 20, 40, 5);

        settle(SWEEP_WAIT);
        if (sb.mismatch_count == 0 && sb.pending_results.size() == 0)
            $display("** name_hash_linear_probe_table_top: PASSED **");
        else
            $display("** name_hash_linear_probe_table_top: FAILED **");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/nhlp_pkg.sv
rtl/core/nhlp_if.sv
rtl/core/nhlp_hash.sv
rtl/core/nhlp_table.sv
rtl/core/name_hash_linear_probe_table_top.sv
verif/tb_name_hash_linear_probe_table_top.sv
